### sv/pid_controller_step_core_macros.svh
// Assertion macros shared by the PID step core RTL.
`ifndef PID_CONTROLLER_STEP_CORE_MACROS_SVH
`define PID_CONTROLLER_STEP_CORE_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define PID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define PID_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### sv/pid_pkg.sv
// Types and constants for the PID step core.
`timescale 1ns / 1ps

package pid_pkg;

    localparam int GAIN_W        = 16;   // unsigned gain width
    localparam int CFG_IDX_W     = 3;    // config register index width
    localparam int OUT_MAX_RESET = 255;  // out_max after reset

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P  = 3'd0,
        CFG_GAIN_I  = 3'd1,
        CFG_GAIN_D  = 3'd2,
        CFG_REVERSE = 3'd3,
        CFG_OUT_MIN = 3'd4,
        CFG_OUT_MAX = 3'd5
    } t_cfg_idx;

endpackage

### sv/pid_controller_step_core.sv
// Positional PID step core: error sum, three gain products, shift, reverse, clamp, zero force.
`timescale 1ns / 1ps
// An accepted input beat passes through stage 1, stage 2, stage 3 and the output register.
// Throughput: one beat per cycle while m_axis_tready is high; stages advance independently, so bubbles
// collapse and a new beat is taken while a finished result waits on m_axis_tready, as long as a stage is empty.
// Error sum and previous error update in the accept cycle (one 33-bit add + saturate).
// Reset (i_rst_n low, synchronous): pipeline empty, state zero, gains 0,
// out_min 0, out_max 255, reverse off.
`include "pid_controller_step_core_macros.svh"

module pid_controller_step_core #(
    parameter int DATA_WIDTH = 16,
    parameter int SUM_WIDTH  = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // sample stream
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [DATA_WIDTH-1:0] setpoint, [2*DATA_WIDTH-1:DATA_WIDTH] measurement, zero pad
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    // drive stream
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // [DATA_WIDTH-1:0] drive, zero pad
    output logic [((DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
    // register write channel
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [pid_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [(DATA_WIDTH > 16 ? DATA_WIDTH : 16)-1:0] i_cfg_data
);

    localparam int GW     = pid_pkg::GAIN_W;
    localparam int ERR_W  = DATA_WIDTH + 1;          // setpoint - measurement
    localparam int DIF_W  = DATA_WIDTH + 2;          // err - previous err
    localparam int LIM_W  = DATA_WIDTH + 1;          // limits hold the 255 reset when DATA_WIDTH >= 8
    localparam int EXT_W  = (SUM_WIDTH > ERR_W ? SUM_WIDTH : ERR_W) + 1;
    localparam int PP_W   = GW + 1 + ERR_W;
    localparam int PD_W   = GW + 1 + DIF_W;
    localparam int PI_W   = GW + 1 + SUM_WIDTH;
    localparam int PMAX_W = (PD_W > PI_W) ? PD_W : PI_W;
    localparam int RAW_W  = PMAX_W + 2;              // exact three-term sum
    localparam int SH_W   = RAW_W - FRAC_BITS;
    localparam int NEG_W  = SH_W + 1;
    localparam int OUT_W  = ((DATA_WIDTH + 7) / 8) * 8;

    localparam logic signed [SUM_WIDTH-1:0] SUM_HI = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_LO = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic signed [EXT_W-1:0]     SUM_HI_X = EXT_W'(SUM_HI);
    localparam logic signed [EXT_W-1:0]     SUM_LO_X = EXT_W'(SUM_LO);

    // ---------------- configuration registers ----------------
    logic [GW-1:0]           r_gain_p, r_gain_i, r_gain_d;
    logic                    r_reverse;
    logic signed [LIM_W-1:0] r_out_min, r_out_max;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= '0;
            r_gain_i  <= '0;
            r_gain_d  <= '0;
            r_reverse <= 1'b0;
            r_out_min <= '0;
            r_out_max <= LIM_W'(pid_pkg::OUT_MAX_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pid_pkg::CFG_GAIN_P:  r_gain_p  <= i_cfg_data[GW-1:0];
                pid_pkg::CFG_GAIN_I:  r_gain_i  <= i_cfg_data[GW-1:0];
                pid_pkg::CFG_GAIN_D:  r_gain_d  <= i_cfg_data[GW-1:0];
                pid_pkg::CFG_REVERSE: r_reverse <= i_cfg_data[0];
                pid_pkg::CFG_OUT_MIN: r_out_min <= LIM_W'($signed(i_cfg_data[DATA_WIDTH-1:0]));
                pid_pkg::CFG_OUT_MAX: r_out_max <= LIM_W'($signed(i_cfg_data[DATA_WIDTH-1:0]));
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // ---------------- stage enables ----------------
    // Each stage loads when empty or when the stage after it loads.
    logic r_v1, r_v2, r_v3, r_ov;
    logic w_ld_o, w_ld3, w_ld2, w_ld1, w_acc;

    assign w_ld_o        = !r_ov || m_axis_tready;
    assign w_ld3         = !r_v3 || w_ld_o;
    assign w_ld2         = !r_v2 || w_ld3;
    assign w_ld1         = !r_v1 || w_ld2;
    assign s_axis_tready = w_ld1;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_ld1)  r_v1 <= w_acc;
            if (w_ld2)  r_v2 <= r_v1;
            if (w_ld3)  r_v3 <= r_v2;
            if (w_ld_o) r_ov <= r_v3;
        end
    end

    // ---------------- accept: error, sum, difference ----------------
    logic signed [DATA_WIDTH-1:0] w_sp, w_meas;
    logic signed [ERR_W-1:0]      w_err;
    logic signed [EXT_W-1:0]      w_sum_x;
    logic signed [SUM_WIDTH-1:0]  w_sum_sat;
    logic signed [DIF_W-1:0]      w_diff;
    logic signed [SUM_WIDTH-1:0]  r_err_sum;
    logic signed [ERR_W-1:0]      r_prev_err;

    assign w_sp    = $signed(s_axis_tdata[DATA_WIDTH-1:0]);
    assign w_meas  = $signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
    assign w_err   = ERR_W'(w_sp) - ERR_W'(w_meas);
    assign w_sum_x = EXT_W'(r_err_sum) + EXT_W'(w_err);
    assign w_diff  = DIF_W'(w_err) - DIF_W'(r_prev_err);

    always_comb begin
        priority if (w_sum_x > SUM_HI_X) w_sum_sat = SUM_HI;
        else if (w_sum_x < SUM_LO_X)     w_sum_sat = SUM_LO;
        else                             w_sum_sat = w_sum_x[SUM_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_sum  <= '0;
            r_prev_err <= '0;
        end else if (w_acc) begin
            r_err_sum  <= w_sum_sat;
            r_prev_err <= w_err;
        end
    end

    logic signed [ERR_W-1:0]     r1_err;
    logic signed [DIF_W-1:0]     r1_diff;
    logic signed [SUM_WIDTH-1:0] r1_sum;
    logic                        r1_zero;

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r1_err  <= w_err;
            r1_diff <= w_diff;
            r1_sum  <= w_sum_sat;
            r1_zero <= (w_sp == '0) && (w_meas == '0);
        end
    end

    // ---------------- stage 2: gain products ----------------
    logic signed [PP_W-1:0] r2_p;
    logic signed [PI_W-1:0] r2_i;
    logic signed [PD_W-1:0] r2_d;
    logic                   r2_zero;

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r2_p    <= $signed({1'b0, r_gain_p}) * r1_err;
            r2_i    <= $signed({1'b0, r_gain_i}) * r1_sum;
            r2_d    <= $signed({1'b0, r_gain_d}) * r1_diff;
            r2_zero <= r1_zero;
        end
    end

    // ---------------- stage 3: sum and floor shift ----------------
    logic signed [RAW_W-1:0] w_raw, w_raw_sh;
    logic signed [SH_W-1:0]  r3_sh;
    logic                    r3_zero;

    assign w_raw    = RAW_W'(r2_p) + RAW_W'(r2_i) + RAW_W'(r2_d);
    assign w_raw_sh = w_raw >>> FRAC_BITS;  // arithmetic: rounds toward minus infinity

    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r3_sh   <= $signed(w_raw_sh[SH_W-1:0]);
            r3_zero <= r2_zero;
        end
    end

    // ---------------- output: reverse, clamp, zero force ----------------
    logic signed [NEG_W-1:0]      w_dir, w_max_x, w_min_x, w_clamp;
    logic signed [DATA_WIDTH-1:0] r_out_drive;
    logic                         r_out_zero;

    assign w_dir   = r_reverse ? -NEG_W'(r3_sh) : NEG_W'(r3_sh);
    assign w_max_x = NEG_W'(r_out_max);
    assign w_min_x = NEG_W'(r_out_min);

    // max is tested first; with crossed limits a drive above out_max resolves to out_max, any other to out_min
    always_comb begin
        priority if (r3_zero)   w_clamp = '0;
        else if (w_dir > w_max_x) w_clamp = w_max_x;
        else if (w_dir < w_min_x) w_clamp = w_min_x;
        else                    w_clamp = w_dir;
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_o) begin
            r_out_drive <= w_clamp[DATA_WIDTH-1:0];
            r_out_zero  <= r3_zero;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = OUT_W'($unsigned(r_out_drive));

    // ---------------- checks ----------------
    `PID_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "output valid right after reset")
    `PID_ASSERT(a_sum_sticks, (w_acc && r_err_sum == SUM_HI && !w_err[ERR_W-1]) |=> (r_err_sum == SUM_HI), "error sum left positive saturation")
    `PID_ASSERT(a_stage3_hold, (r_v3 && !w_ld3) |=> (r_v3 && $stable(r3_sh)), "stage 3 overwritten while stalled")
    `PID_ASSERT(a_drive_in_range, (r_ov && !r_out_zero && r_out_min <= r_out_max) |-> (LIM_W'(r_out_drive) >= r_out_min && LIM_W'(r_out_drive) <= r_out_max), "drive outside limits")

endmodule
